// ----- rtl/frocm_pkg.sv -----
// ----------------------------------------------------------------------------
// frocm_pkg: shared widths, types and constants
// Widths of the period count, frequency, product and quotient paths of the
// frequency and rate-of-change meter, plus the control struct of the divider.
// ----------------------------------------------------------------------------
package frocm_pkg;

   // Sizing constants
   localparam int COUNT_BITS = 16;                    // used bits of the period count
   localparam int FRAC_BITS  = 16;                    // fraction bits of the results

   localparam int IN_W     = 16;                      // sample_count field
   localparam int CNT_W    = COUNT_BITS;
   localparam int RATE_W   = 16;                      // sample_rate_hz register
   localparam int FREQ_W   = 32;                      // frequency_q16 field
   localparam int OUT_W    = 32;                      // rate_q16 field
   localparam int FDIV_W   = RATE_W + FRAC_BITS;      // frequency dividend bits
   localparam int PROD_W   = FREQ_W + RATE_W;         // difference times rate
   localparam int DIV_W    = PROD_W;                  // shared divider length
   localparam int DIV_CNT_W = $clog2(DIV_W + 1);
   localparam int MUL_CNT_W = $clog2(RATE_W + 1);

   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = FREQ_W + OUT_W;
   localparam int RSP_USER_W = 2;

   // Bit positions in rsp_tuser
   localparam int USER_RATE_VALID  = 0;
   localparam int USER_COUNT_ERROR = 1;

   localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(16000);
   localparam logic [FREQ_W-1:0] FREQ_SAT   = '1;
   localparam logic [OUT_W-1:0]  RATE_POS_MAX = {1'b0, {(OUT_W-1){1'b1}}};
   localparam logic [OUT_W-1:0]  RATE_NEG_MAG = {1'b1, {(OUT_W-1){1'b0}}};

   // Divider command
   typedef struct packed {
      logic start;      // load operands and begin
      logic short_op;   // frequency division: FDIV_W quotient bits only
   } div_ctl_type;

endpackage

// ----- rtl/frequency_and_rate_of_change_meter_top.sv -----
// ----------------------------------------------------------------------------
// frequency_and_rate_of_change_meter_top: period count to frequency and ROCOF
// Usage:
//   req_* carries one period measurement (samples per signal period) per
//   transaction. rsp_* returns one result per request: frequency in unsigned
//   Q16, rate of change in signed saturating Q16, and two flags in tuser.
//   csr_* writes sample_rate_hz; write only while no request is in flight.
// Sequence:
//   A normal item runs the serial divider for the frequency, then the
//   serial multiplier and the divider again for the rate, with sequencing
//   states between them. The first nonzero count after reset skips the
//   rate path, and a zero count skips both. The next request is accepted
//   in the cycle after the result is loaded. The single shared divider,
//   one quotient bit per cycle, sets the pace; one item is in work at a
//   time.
// Reset:
//   sample_rate_hz returns to 16000 and the previous measurement is cleared,
//   so the next result has rate_valid low.
// Stall:
//   The result sits in an output register; the next request is accepted and
//   computed while it waits, and that one then holds until rsp_tready.
// ----------------------------------------------------------------------------
module frequency_and_rate_of_change_meter_top (
   input  logic                              clock,
   input  logic                              reset,
   // request: [15:0] sample_count
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [frocm_pkg::REQ_DATA_W-1:0]  req_tdata,
   // response: [31:0] frequency_q16, [63:32] rate_q16
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [frocm_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // response flags: [0] rate_valid, [1] count_error
   output logic [frocm_pkg::RSP_USER_W-1:0]  rsp_tuser,
   // configuration: [15:0] sample_rate_hz
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [frocm_pkg::RATE_W-1:0]      csr_wdata
);
   import frocm_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_FDIV = 6'b000010,
      ST_SUB  = 6'b000100,
      ST_MUL  = 6'b001000,
      ST_RDIV = 6'b010000,
      ST_FIN  = 6'b100000
   } state_type;

   state_type         state_ff, state_in;
   logic [RATE_W-1:0] rate_cfg_ff, rate_cfg_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [FREQ_W-1:0] freq_ff, freq_in;
   logic              neg_ff, neg_in;
   logic [OUT_W-1:0]  res_rate_ff, res_rate_in;
   logic              res_valid_ff, res_valid_in;
   logic              res_err_ff, res_err_in;
   logic [FREQ_W-1:0] prev_freq_ff, prev_freq_in;
   logic [CNT_W-1:0]  prev_count_ff, prev_count_in;
   logic              have_prev_ff, have_prev_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [FREQ_W-1:0] rsp_freq_ff, rsp_freq_in;
   logic [OUT_W-1:0]  rsp_rate_ff, rsp_rate_in;
   logic              rsp_rvalid_ff, rsp_rvalid_in;
   logic              rsp_err_ff, rsp_err_in;

   div_ctl_type       div_ctl;
   logic [DIV_W-1:0]  div_dividend;
   logic [CNT_W-1:0]  div_divisor;
   logic [DIV_W-1:0]  div_q;
   logic              div_done;
   logic              mul_start;
   logic [FREQ_W-1:0] mul_mcand;
   logic [PROD_W-1:0] mul_prod;
   logic              mul_done;

   logic              req_fire;
   logic              out_free;
   logic [CNT_W-1:0]  count_new;
   logic [CNT_W:0]    count_sum;
   logic [CNT_W-1:0]  mean;
   logic [FREQ_W-1:0] freq_sat;
   logic              freq_lt;
   logic              pos_over;
   logic              neg_over;
   logic [OUT_W-1:0]  neg_mag;
   logic [OUT_W-1:0]  rate_sat;

   assign req_fire  = req_tvalid && req_tready;
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign count_new = CNT_W'(req_tdata[IN_W-1:0]);
   assign csr_ready = 1'b1;

   // truncated mean of the new and previous counts
   assign count_sum = {1'b0, count_ff} + {1'b0, prev_count_ff};
   assign mean      = count_sum[CNT_W:1];

   // frequency quotient clipped to the field width
   assign freq_sat = (|div_q[DIV_W-1:FREQ_W]) ? FREQ_SAT : div_q[FREQ_W-1:0];
   assign freq_lt  = freq_ff < prev_freq_ff;

   // rate quotient saturated to the signed range
   assign pos_over = |div_q[DIV_W-1:OUT_W-1];
   assign neg_over = (|div_q[DIV_W-1:OUT_W]) || (div_q[OUT_W-1] && (|div_q[OUT_W-2:0]));
   assign neg_mag  = neg_over ? RATE_NEG_MAG : div_q[OUT_W-1:0];
   assign rate_sat = neg_ff ? (OUT_W'(0) - neg_mag)
                            : (pos_over ? RATE_POS_MAX : div_q[OUT_W-1:0]);

   // sequencer
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      freq_in       = freq_ff;
      neg_in        = neg_ff;
      res_rate_in   = res_rate_ff;
      res_valid_in  = res_valid_ff;
      res_err_in    = res_err_ff;
      prev_freq_in  = prev_freq_ff;
      prev_count_in = prev_count_ff;
      have_prev_in  = have_prev_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_freq_in   = rsp_freq_ff;
      rsp_rate_in   = rsp_rate_ff;
      rsp_rvalid_in = rsp_rvalid_ff;
      rsp_err_in    = rsp_err_ff;
      div_ctl       = '0;
      div_dividend  = {rate_cfg_ff, {(DIV_W-RATE_W){1'b0}}};
      div_divisor   = count_new;
      mul_start     = 1'b0;
      mul_mcand     = freq_lt ? (prev_freq_ff - freq_ff) : (freq_ff - prev_freq_ff);
      req_tready    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_fire) begin
               count_in     = count_new;
               res_rate_in  = '0;
               res_valid_in = 1'b0;
               if (count_new == '0) begin
                  freq_in    = '0;
                  res_err_in = 1'b1;
                  state_in   = ST_FIN;
               end else begin
                  res_err_in       = 1'b0;
                  div_ctl.start    = 1'b1;
                  div_ctl.short_op = 1'b1;
                  state_in         = ST_FDIV;
               end
            end
         end
         ST_FDIV: begin
            if (div_done) begin
               freq_in      = freq_sat;
               res_valid_in = have_prev_ff;
               state_in     = have_prev_ff ? ST_SUB : ST_FIN;
            end
         end
         ST_SUB: begin
            neg_in    = freq_lt;
            mul_start = 1'b1;
            state_in  = ST_MUL;
         end
         ST_MUL: begin
            if (mul_done) begin
               if (mean == '0) begin
                  state_in = ST_FIN;
               end else begin
                  div_ctl.start = 1'b1;
                  div_dividend  = mul_prod;
                  div_divisor   = mean;
                  state_in      = ST_RDIV;
               end
            end
         end
         ST_RDIV: begin
            if (div_done) begin
               res_rate_in = rate_sat;
               state_in    = ST_FIN;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_freq_in   = freq_ff;
               rsp_rate_in   = res_rate_ff;
               rsp_rvalid_in = res_valid_ff;
               rsp_err_in    = res_err_ff;
               if (!res_err_ff) begin
                  prev_freq_in  = freq_ff;
                  prev_count_in = count_ff;
                  have_prev_in  = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // configuration register
   always_comb begin
      rate_cfg_in = rate_cfg_ff;
      if (csr_valid && csr_ready) begin
         rate_cfg_in = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rate_cfg_ff   <= RATE_RESET;
         prev_freq_ff  <= '0;
         prev_count_ff <= '0;
         have_prev_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rate_cfg_ff   <= rate_cfg_in;
         prev_freq_ff  <= prev_freq_in;
         prev_count_ff <= prev_count_in;
         have_prev_ff  <= have_prev_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      count_ff      <= count_in;
      freq_ff       <= freq_in;
      neg_ff        <= neg_in;
      res_rate_ff   <= res_rate_in;
      res_valid_ff  <= res_valid_in;
      res_err_ff    <= res_err_in;
      rsp_freq_ff   <= rsp_freq_in;
      rsp_rate_ff   <= rsp_rate_in;
      rsp_rvalid_ff <= rsp_rvalid_in;
      rsp_err_ff    <= rsp_err_in;
   end

   frocm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .ctl      (div_ctl),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_q),
      .done     (div_done)
   );

   frocm_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (mul_mcand),
      .mplier  (rate_cfg_ff),
      .product (mul_prod),
      .done    (mul_done)
   );

   // response outputs
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_rate_ff, rsp_freq_ff};
   always_comb begin
      rsp_tuser                   = '0;
      rsp_tuser[USER_RATE_VALID]  = rsp_rvalid_ff;
      rsp_tuser[USER_COUNT_ERROR] = rsp_err_ff;
   end

   // checks
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while an item was in work");

   a_error_zero_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[USER_COUNT_ERROR] |->
         rsp_tdata == '0 && !rsp_tuser[USER_RATE_VALID])
      else $error("count error result carries nonzero fields");

   a_no_rate_without_prev: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[USER_RATE_VALID] |-> rsp_tdata[RSP_DATA_W-1:FREQ_W] == '0)
      else $error("rate nonzero without a previous measurement");

   a_result_holds_on_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |=> rsp_valid_ff && $stable(rsp_freq_ff)
         && $stable(rsp_rate_ff))
      else $error("stalled result register changed");

endmodule

// ----- rtl/frocm_div.sv -----
// ----------------------------------------------------------------------------
// frocm_div: bit-serial restoring divider
// One quotient bit per cycle. The dividend is left aligned in a DIV_W shift
// register; quotient bits shift in at the bottom as dividend bits leave.
// ----------------------------------------------------------------------------
module frocm_div (
   input  logic                          clock,
   input  logic                          reset,
   input  frocm_pkg::div_ctl_type        ctl,
   input  logic [frocm_pkg::DIV_W-1:0]   dividend,
   input  logic [frocm_pkg::CNT_W-1:0]   divisor,
   output logic [frocm_pkg::DIV_W-1:0]   quotient,
   output logic                          done
);
   import frocm_pkg::*;

   logic [DIV_W-1:0]     q_ff, q_in;
   logic [CNT_W-1:0]     rem_ff, rem_in;
   logic [CNT_W-1:0]     dsr_ff, dsr_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic [CNT_W:0]       trial;
   logic [CNT_W:0]       diff;
   logic                 fits;

   // one restoring step
   assign trial = {rem_ff, q_ff[DIV_W-1]};
   assign diff  = trial - {1'b0, dsr_ff};
   assign fits  = trial >= {1'b0, dsr_ff};

   always_comb begin
      q_in    = q_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (ctl.start) begin
         q_in   = dividend;
         rem_in = '0;
         dsr_in = divisor;
         cnt_in = ctl.short_op ? DIV_CNT_W'(FDIV_W) : DIV_CNT_W'(DIV_W);
         run_in = 1'b1;
      end else if (run_ff) begin
         q_in   = {q_ff[DIV_W-2:0], fits};
         rem_in = fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
         cnt_in = cnt_ff - DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      q_ff   <= q_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign quotient = q_ff;
   assign done     = done_ff;

endmodule

// ----- rtl/frocm_mul.sv -----
// ----------------------------------------------------------------------------
// frocm_mul: bit-serial shift-add multiplier
// Multiplier bits are consumed LSB first, one per cycle; the partial sum
// and the remaining multiplier bits share one product shift register.
// ----------------------------------------------------------------------------
module frocm_mul (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [frocm_pkg::FREQ_W-1:0]  mcand,
   input  logic [frocm_pkg::RATE_W-1:0]  mplier,
   output logic [frocm_pkg::PROD_W-1:0]  product,
   output logic                          done
);
   import frocm_pkg::*;

   logic [PROD_W-1:0]    p_ff, p_in;
   logic [FREQ_W-1:0]    mc_ff, mc_in;
   logic [MUL_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic [FREQ_W:0]      sum;

   // add multiplicand into the upper FREQ_W bits when the current bit is set
   assign sum = {1'b0, p_ff[PROD_W-1:RATE_W]} + (p_ff[0] ? {1'b0, mc_ff} : '0);

   always_comb begin
      p_in    = p_ff;
      mc_in   = mc_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         p_in   = {{FREQ_W{1'b0}}, mplier};
         mc_in  = mcand;
         cnt_in = MUL_CNT_W'(RATE_W);
         run_in = 1'b1;
      end else if (run_ff) begin
         p_in   = {sum, p_ff[RATE_W-1:1]};
         cnt_in = cnt_ff - MUL_CNT_W'(1);
         if (cnt_ff == MUL_CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      p_ff  <= p_in;
      mc_ff <= mc_in;
   end

   assign product = p_ff;
   assign done    = done_ff;

endmodule

// ----- bench/tb_frequency_and_rate_of_change_meter_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_frequency_and_rate_of_change_meter_top: self-checking bench of the meter
// Streams period counts through the request channel under random bursts and
// response back-pressure. Every response is checked against a predicted
// frequency, rate of change and flag pair. The sample rate is rewritten only
// while the meter is idle. Settings include the reset rate, the extremes and
// random values.
// ----------------------------------------------------------------------------
module tb_frequency_and_rate_of_change_meter_top;
   import frocm_pkg::*;

   localparam int SETTLE_CYCLES = 150;   // longer than one full item latency
   localparam int RANDOM_PER_PHASE = 76;
   localparam int PHASES = 7;

   typedef struct packed {
      logic [FREQ_W-1:0] frequency;
      logic [OUT_W-1:0]  rate;
      logic              rate_valid;
      logic              count_error;
   } meter_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [RATE_W-1:0]     csr_wdata = '0;

   // Predictor state: register copy and previous measurement
   logic [RATE_W-1:0] sample_rate = RATE_RESET;
   logic [FREQ_W-1:0] last_freq = '0;
   logic [CNT_W-1:0]  last_count = '0;
   logic              have_last = 1'b0;

   logic [REQ_DATA_W-1:0] pending_counts[$];
   meter_result_type      expected_results[$];

   int errors = 0;
   int requests_sent = 0;
   int results_checked = 0;
   int zero_counts = 0;
   int saturated_rates = 0;
   int rate_settings = 1;
   int drift_base = 320;

   int gap_left = 0;
   int burst_left = 0;
   int stall_left = 0;
   int ready_left = 0;

   frequency_and_rate_of_change_meter_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   // 100 MHz clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Expected result of one period count; updates the previous measurement unless the count is zero
   function automatic meter_result_type measure_period(input logic [REQ_DATA_W-1:0] raw);
      meter_result_type r;
      logic [63:0]   count;
      logic [63:0]   freq;
      logic [63:0]   mean;
      logic [63:0]   mag;
      logic [63:0]   quo;
      logic          falling;
      r = '0;
      count = 64'(raw[CNT_W-1:0]);
      if (count == 0) begin
         r.count_error = 1'b1;
         zero_counts++;
         return r;
      end
      freq = (64'(sample_rate) << FRAC_BITS) / count;
      if (freq > 64'(FREQ_SAT))
         freq = 64'(FREQ_SAT);
      if (have_last) begin
         r.rate_valid = 1'b1;
         mean = (count + 64'(last_count)) >> 1;
         if (mean != 0) begin
            falling = freq < 64'(last_freq);
            mag = falling ? 64'(last_freq) - freq : freq - 64'(last_freq);
            quo = (mag * 64'(sample_rate)) / mean;
            if (falling) begin
               if (quo > 64'(RATE_NEG_MAG)) begin
                  quo = 64'(RATE_NEG_MAG);
                  saturated_rates++;
               end
               r.rate = 32'd0 - quo[OUT_W-1:0];
            end else begin
               if (quo > 64'(RATE_POS_MAX)) begin
                  quo = 64'(RATE_POS_MAX);
                  saturated_rates++;
               end
               r.rate = quo[OUT_W-1:0];
            end
         end
      end
      last_freq = freq[FREQ_W-1:0];
      last_count = count[CNT_W-1:0];
      have_last = 1'b1;
      r.frequency = freq[FREQ_W-1:0];
      return r;
   endfunction

   // Slow drift around a base period for nearly half of the counts, plus noise, zeros and extremes
   function automatic logic [REQ_DATA_W-1:0] next_count();
      int pick;
      pick = $urandom_range(0, 19);
      if (pick < 9) begin
         drift_base = drift_base + int'($urandom_range(0, 64)) - 32;
         if (drift_base < 1) drift_base = 1;
         if (drift_base > 65535) drift_base = 65535;
         return REQ_DATA_W'(drift_base);
      end
      if (pick < 14) return REQ_DATA_W'($urandom_range(0, 65535));
      if (pick < 16) return '0;
      if (pick < 18) return REQ_DATA_W'($urandom_range(1, 15));
      return REQ_DATA_W'(65535 - $urandom_range(0, 600));
   endfunction

   function automatic int pick_gap();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 4) return 0;
      if (pick < 8) return $urandom_range(1, 8);
      return $urandom_range(20, 160);
   endfunction

   function automatic int pick_stall();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 3) return 0;
      if (pick < 7) return $urandom_range(1, 4);
      return $urandom_range(30, 150);
   endfunction

   // Wait for an empty pipeline, then let the meter finish any tail work;
   // sampled mid-cycle so the driver's updates of this edge are visible
   task automatic wait_idle();
      @(negedge clock);
      while (pending_counts.size() != 0 || req_tvalid || expected_results.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One register write transaction
   task automatic write_sample_rate(input logic [RATE_W-1:0] value);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do
         @(posedge clock);
      while (!(csr_valid && csr_ready));
      csr_valid <= 1'b0;
      sample_rate = value;
      rate_settings++;
   endtask

   // Request driver: bursts of random length separated by random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
         gap_left <= 0;
         burst_left <= $urandom_range(1, 16);
      end else begin
         if (req_tvalid && req_tready) begin
            expected_results.push_back(measure_period(req_tdata));
            requests_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left != 0) begin
               gap_left <= gap_left - 1;
               req_tvalid <= 1'b0;
            end else if (pending_counts.size() != 0) begin
               req_tvalid <= 1'b1;
               req_tdata <= pending_counts.pop_front();
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 16);
                  gap_left <= pick_gap();
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Response monitor and back-pressure
   always @(posedge clock) begin : response_check
      meter_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
         ready_left <= $urandom_range(1, 24);
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_checked++;
            if (expected_results.size() == 0) begin
               errors++;
               $display("%0t: unexpected result freq=%h rate=%h flags=%b",
                        $time, rsp_tdata[FREQ_W-1:0], rsp_tdata[RSP_DATA_W-1:FREQ_W],
                        rsp_tuser);
            end else begin
               want = expected_results.pop_front();
               if (rsp_tdata[FREQ_W-1:0] !== want.frequency) begin
                  errors++;
                  $display("%0t: frequency_q16 expected %h actual %h", $time,
                           want.frequency, rsp_tdata[FREQ_W-1:0]);
               end
               if (rsp_tdata[RSP_DATA_W-1:FREQ_W] !== want.rate) begin
                  errors++;
                  $display("%0t: rate_q16 expected %0d actual %0d", $time,
                           $signed(want.rate), $signed(rsp_tdata[RSP_DATA_W-1:FREQ_W]));
               end
               if (rsp_tuser[USER_RATE_VALID] !== want.rate_valid) begin
                  errors++;
                  $display("%0t: rate_valid expected %b actual %b", $time,
                           want.rate_valid, rsp_tuser[USER_RATE_VALID]);
               end
               if (rsp_tuser[USER_COUNT_ERROR] !== want.count_error) begin
                  errors++;
                  $display("%0t: count_error expected %b actual %b", $time,
                           want.count_error, rsp_tuser[USER_COUNT_ERROR]);
               end
            end
         end
         if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (ready_left <= 1) begin
               // now and then a long stretch without stalls
               ready_left <= ($urandom_range(0, 7) == 0) ? 300 : $urandom_range(1, 24);
               stall_left <= pick_stall();
            end else begin
               ready_left <= ready_left - 1;
            end
         end
      end
   end

   // Stimulus sequence: phases at different sample rates
   initial begin : stimulus
      logic [RATE_W-1:0] phase_rate;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset rate: zero before any measurement, first item, extremes
      pending_counts = '{16'd0, 16'd1, 16'd0, 16'hFFFF, 16'd1, 16'd2,
                         16'hAAAA, 16'h5555, 16'd320};
      for (int p = 0; p < PHASES; p++) begin
         if (p != 0) begin
            wait_idle();
            case (p)
               1: phase_rate = 16'hFFFF;
               2: phase_rate = 16'd1;
               3: phase_rate = 16'd0;   // zero rate, still accepted
               6: phase_rate = 16'd48000;
               default: phase_rate = RATE_W'($urandom_range(0, 65535));
            endcase
            write_sample_rate(phase_rate);
            // full-scale jumps that saturate both directions
            if (p == 1)
               pending_counts = '{16'd1, 16'hFFFF, 16'd1, 16'd2};
         end
         drift_base = $urandom_range(40, 3000);
         repeat (RANDOM_PER_PHASE) pending_counts.push_back(next_count());
      end

      wait_idle();
      $display("Checked %0d results from %0d requests over %0d sample-rate settings",
               results_checked, requests_sent, rate_settings);
      $display("Zero counts: %0d, saturated rates: %0d", zero_counts, saturated_rates);
      if (errors == 0 && expected_results.size() == 0) begin
         $display("PASS frequency_and_rate_of_change_meter_top");
      end else begin
         $display("FAIL frequency_and_rate_of_change_meter_top");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #10_000_000;
      $display("FAIL frequency_and_rate_of_change_meter_top");
      $finish;
   end

endmodule
